>>> src/char_lcd_nibble_writer_core_macros.svh
// Assertion macros for the character LCD nibble writer.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef CHAR_LCD_NIBBLE_WRITER_CORE_MACROS_SVH
`define CHAR_LCD_NIBBLE_WRITER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CLNW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("clnw same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CLNW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clnw next-cycle check failed");

`endif

>>> src/clnw_pkg.sv
// Shared types, codes and sequence tables for the LCD nibble writer.
// No dependencies.
`default_nettype none
package clnw_pkg;

  localparam logic [1:0] ACT_INIT = 2'd0;
  localparam logic [1:0] ACT_CMD  = 2'd1;
  localparam logic [1:0] ACT_DATA = 2'd2;

  localparam logic [7:0]  CMD_CLEAR     = 8'h01;
  localparam logic [13:0] CLEAR_GAP_US  = 14'd10000;
  localparam logic [13:0] NORMAL_GAP_US = 14'd50;
  localparam logic [13:0] INNER_GAP_US  = 14'd10;

  localparam int          INIT_LEN  = 14;
  localparam logic [3:0]  INIT_LAST = 4'(INIT_LEN - 1);

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] byte_value;
  } lcd_in_t;

  typedef struct packed {
    logic        reg_select;
    logic [3:0]  nibble;
    logic [13:0] wait_before_us;
    logic        last;
  } lcd_out_t;

  // Classified job handed from front to back
  typedef struct packed {
    logic        is_init;
    logic        reg_select;
    logic [7:0]  byte_value;
    logic [13:0] first_wait;
  } job_t;

  function automatic logic [3:0] init_nibble(input logic [3:0] idx);
    logic [3:0] n;
    case (idx)
      4'd0, 4'd1, 4'd2: n = 4'h3;
      4'd3, 4'd4:       n = 4'h2;
      4'd5:             n = 4'hC;
      4'd7:             n = 4'h8;
      4'd9:             n = 4'h1;
      4'd11:            n = 4'h6;
      4'd13:            n = 4'hD;
      default:          n = 4'h0;
    endcase
    return n;
  endfunction

  function automatic logic [13:0] init_wait(input logic [3:0] idx);
    logic [13:0] w;
    case (idx)
      4'd0:                          w = 14'd15000;
      4'd1:                          w = 14'd5000;
      4'd2:                          w = 14'd200;
      4'd3:                          w = 14'd50;
      4'd4:                          w = 14'd0;
      4'd6, 4'd8, 4'd10, 4'd12:      w = 14'd10000;
      4'd5, 4'd7, 4'd9, 4'd11, 4'd13: w = 14'd10;
      default:                       w = 14'd0;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

>>> src/char_lcd_nibble_writer_core.sv
// Character LCD 4-bit nibble writer, top level.
// An accepted word passes through a queue slot, the job register and the output register before
// its first nibble word is valid at the output. A byte gives two nibble words, an init request
// fourteen; the back end emits one per cycle while out_ready does not stall it, after fetching each job.
// A two-entry queue lets input words be taken while the back end is busy.
// Reset (synchronous, active low) clears the owed gap, the queue and the back end.
`default_nettype none
module char_lcd_nibble_writer_core import clnw_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire lcd_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output lcd_out_t     out_data
);

  logic q_push, q_full, q_pop, q_empty;
  job_t push_job, pop_job;

  clnw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  clnw_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_job (push_job),
    .full   (q_full),
    .pop    (q_pop),
    .empty  (q_empty),
    .rd_job (pop_job)
  );

  clnw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (pop_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

>>> src/clnw_front.sv
// Front end: accepts input words, drops unused codes, tracks the owed gap.
// Depends on clnw_pkg.
`default_nettype none
module clnw_front import clnw_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire lcd_in_t in_data,
  input  wire logic    q_full,
  output logic         q_push,
  output job_t         q_job
);

  logic [13:0] owed_gap_r, owed_gap_nxt;
  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    q_push       = 1'b0;
    owed_gap_nxt = owed_gap_r;
    q_job.is_init    = (in_data.action == ACT_INIT);
    q_job.reg_select = (in_data.action == ACT_DATA);
    q_job.byte_value = in_data.byte_value;
    q_job.first_wait = owed_gap_r;
    if (accept) begin
      case (in_data.action)
        ACT_INIT: begin
          q_push       = 1'b1;
          owed_gap_nxt = NORMAL_GAP_US;
        end
        ACT_CMD: begin
          q_push       = 1'b1;
          owed_gap_nxt = (in_data.byte_value == CMD_CLEAR) ? CLEAR_GAP_US : NORMAL_GAP_US;
        end
        ACT_DATA: begin
          q_push       = 1'b1;
          owed_gap_nxt = NORMAL_GAP_US;
        end
        default: begin
          // drop unused code
          q_push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owed_gap_r <= '0;
    end else begin
      owed_gap_r <= owed_gap_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/clnw_queue.sv
// Two-entry job queue between front and back ends.
// Depends on clnw_pkg.
`default_nettype none
module clnw_queue import clnw_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t wr_job,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output job_t      rd_job
);

  job_t       slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_job  = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= wr_job;
  end

endmodule
`default_nettype wire

>>> src/clnw_back.sv
// Back end: steps through each job and emits one nibble word per cycle while out_ready does not stall it.
// Depends on clnw_pkg and the assertion macros header.
`default_nettype none
`include "char_lcd_nibble_writer_core_macros.svh"
module clnw_back import clnw_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_empty,
  input  wire job_t q_job,
  output logic      q_pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output lcd_out_t  out_data
);

  logic       busy_r, busy_nxt;
  logic [3:0] step_r, step_nxt;
  job_t       job_r;
  lcd_out_t   out_r, gen;
  logic       out_valid_r, out_valid_nxt;
  logic       load;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign load      = busy_r && (!out_valid_r || out_ready);
  assign q_pop     = !busy_r && !q_empty;

  always_comb begin
    if (job_r.is_init) begin
      gen.reg_select     = 1'b0;
      gen.nibble         = init_nibble(step_r);
      gen.wait_before_us = init_wait(step_r);
      gen.last           = (step_r == INIT_LAST);
    end else begin
      gen.reg_select     = job_r.reg_select;
      gen.nibble         = step_r[0] ? job_r.byte_value[3:0] : job_r.byte_value[7:4];
      gen.wait_before_us = step_r[0] ? INNER_GAP_US : job_r.first_wait;
      gen.last           = step_r[0];
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (q_pop) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (load) begin
      out_valid_nxt = 1'b1;
      if (gen.last) begin
        busy_nxt = 1'b0;
        step_nxt = '0;
      end else begin
        step_nxt = step_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) job_r <= q_job;
    if (load)  out_r <= gen;
  end

  `CLNW_ASSERT_NOW(a_init_step_range, busy_r && job_r.is_init, step_r <= INIT_LAST)
  `CLNW_ASSERT_NOW(a_byte_step_range, busy_r && !job_r.is_init, step_r <= 4'd1)
  `CLNW_ASSERT_NEXT(a_last_ends_job, load && gen.last, !busy_r)
  `CLNW_ASSERT_NEXT(a_pop_starts_at_zero, q_pop, busy_r && (step_r == 4'd0))

endmodule
`default_nettype wire
